FILE: rtl/owpd_pkg.sv
package owpd_pkg;

    localparam int TABLE_ENTRIES = 22;
    localparam int LEVEL_STEPS   = 32;
    localparam int MAX_LEVEL     = 32;
    localparam int FULL_REQ      = 255;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] THR_REQ [TABLE_ENTRIES] = '{
        8'd20,  8'd27,  8'd39,  8'd51,  8'd63,  8'd75,  8'd87,  8'd99,
        8'd111, 8'd123, 8'd135, 8'd147, 8'd159, 8'd171, 8'd183, 8'd195,
        8'd207, 8'd220, 8'd230, 8'd235, 8'd240, 8'd255
    };
    localparam logic [5:0] THR_LVL [TABLE_ENTRIES] = '{
        6'd29, 6'd29, 6'd28, 6'd28, 6'd27, 6'd26, 6'd25, 6'd22,
        6'd20, 6'd18, 6'd17, 6'd16, 6'd16, 6'd14, 6'd14, 6'd12,
        6'd12, 6'd11, 6'd10, 6'd9,  6'd8,  6'd3
    };

    localparam logic CFG_IDX_DIMMING = 1'b0;
    localparam logic CFG_IDX_MIN     = 1'b1;

    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_SUSPEND = 2'd1,
        OP_RESUME  = 2'd2,
        OP_MANUAL  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_LOW_HOLD = 2'd0,
        ACT_LOW      = 2'd1,
        ACT_PULSE    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEAD,
        ST_PULSE
    } back_state_t;

    typedef struct packed {
        logic [5:0] dimming_level;
        logic [7:0] min_brightness;
    } cfg_t;

    typedef struct packed {
        logic       lead;
        action_t    lead_action;
        logic [5:0] count;
        logic [5:0] level;
        logic [7:0] bright;
    } job_t;

    function automatic logic [5:0] owpd_target(
        input logic [7:0] req,
        input logic [2:0] flags,
        input cfg_t       cfg
    );
        logic [5:0] t;
        t = 6'd0;
        if (!flags[0] || !flags[1] || flags[2] || req == 8'd0) begin
            t = 6'd0;
        end else if (req < cfg.min_brightness) begin
            t = (cfg.dimming_level > 6'(MAX_LEVEL)) ? 6'(MAX_LEVEL) : cfg.dimming_level;
        end else if (req == 8'(FULL_REQ)) begin
            t = THR_LVL[TABLE_ENTRIES - 1];
        end else begin
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                if (req <= THR_REQ[i]) begin
                    t = THR_LVL[i];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [5:0] owpd_steps(
        input logic [5:0] cur,
        input logic [5:0] tgt
    );
        logic [6:0] diff;
        logic [6:0] n;
        diff = 7'd0;
        if (cur <= tgt) begin
            n = {1'b0, tgt} - {1'b0, cur};
        end else begin
            diff = ({1'b0, cur} - {1'b0, tgt}) % 7'(LEVEL_STEPS);
            n    = (7'(LEVEL_STEPS) - diff) % 7'(LEVEL_STEPS);
        end
        if (n > 7'(MAX_LEVEL)) begin
            n = 7'(MAX_LEVEL);
        end
        return n[5:0];
    endfunction

endpackage

FILE: rtl/owpd_if.sv
interface owpd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] brightness;
    logic       power_unblank;
    logic       fb_unblank;
    logic       core_suspended;
    logic [5:0] manual_pulses;

    modport source (
        output valid, operation, brightness, power_unblank, fb_unblank,
               core_suspended, manual_pulses,
        input  ready
    );
    modport sink (
        input  valid, operation, brightness, power_unblank, fb_unblank,
               core_suspended, manual_pulses,
        output ready
    );
endinterface

interface owpd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       last;
    logic [5:0] level;
    logic [7:0] reported_brightness;

    modport source (
        output valid, action, last, level, reported_brightness,
        input  ready
    );
    modport sink (
        input  valid, action, last, level, reported_brightness,
        output ready
    );
endinterface

FILE: rtl/one_wire_pulse_dimming_control_top.sv
// Turns brightness, suspend, resume and manual-pulse requests into line events for a
// one-wire pulse-count backlight chip: drive low with hold, drive low, or one pulse.
// A request is accepted whenever the two-entry job queue has room, so requests can
// arrive every cycle until the queue fills; the result sequencer then emits one result
// per cycle while the receiver is ready, 0 to 33 per request (up to 32 pulses, plus a
// leading low hold for a manual count), and starts the next queued job in the cycle
// after the last result of the previous one is taken. Every result of a request
// carries the level in effect after it and the last brightness requested.
module one_wire_pulse_dimming_control_top
    import owpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    owpd_req_if.sink    req,
    owpd_res_if.source  res,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [5:0] dimming_reg;
    logic [7:0] min_reg;
    cfg_t       cfg;
    logic       push;
    job_t       push_job;
    logic       q_full;
    logic       q_empty;
    logic       pop;
    job_t       q_head;

    assign cfg.dimming_level  = dimming_reg;
    assign cfg.min_brightness = min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimming_reg <= 6'd32;
            min_reg     <= 8'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_DIMMING: dimming_reg <= cfg_data[5:0];
                CFG_IDX_MIN:     min_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    owpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req      (req),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    owpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    owpd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .res     (res)
    );

    a_final_hold_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.action == ACT_LOW_HOLD && res.last |-> res.level == 6'd0)
        else $error("final low-hold result with nonzero level");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.level <= 6'(MAX_LEVEL))
        else $error("result level above maximum");

    a_suspend_single: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.action == ACT_LOW |-> res.last && res.level == 6'd0)
        else $error("drive-low result not a single final result at level zero");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full && !pop |=> !(push && q_full) || pop)
        else $error("job pushed into full queue");

endmodule

FILE: rtl/owpd_front.sv
module owpd_front
    import owpd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    owpd_req_if.sink      req,
    input  logic          q_full,
    output logic          push,
    output job_t          push_job
);

    logic [5:0] level_reg;
    logic [5:0] level_next;
    logic       resumed_reg;
    logic       resumed_next;
    logic [7:0] bright_reg;
    logic [7:0] bright_next;
    logic [2:0] flags_reg;
    logic [2:0] flags_next;

    logic       accept;
    op_t        op;
    logic       apply_en;
    logic [5:0] tgt;
    logic [5:0] steps;
    logic       has_job;

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign op        = op_t'(req.operation);

    always_comb
    begin
        bright_next  = bright_reg;
        flags_next   = flags_reg;
        resumed_next = resumed_reg;
        level_next   = level_reg;
        apply_en     = 1'b0;
        has_job      = 1'b0;
        push_job     = '0;

        unique case (op)
            OP_UPDATE:
            begin
                bright_next = req.brightness;
                flags_next  = {req.core_suspended, req.fb_unblank, req.power_unblank};
                apply_en    = resumed_reg;
            end
            OP_SUSPEND:
            begin
                resumed_next         = 1'b0;
                level_next           = 6'd0;
                has_job              = 1'b1;
                push_job.lead        = 1'b1;
                push_job.lead_action = ACT_LOW;
                push_job.count       = 6'd0;
            end
            OP_RESUME:
            begin
                resumed_next = 1'b1;
                apply_en     = 1'b1;
            end
            OP_MANUAL:
            begin
                if (req.manual_pulses >= 6'd1 && req.manual_pulses <= 6'(MAX_LEVEL))
                begin
                    has_job              = 1'b1;
                    push_job.lead        = 1'b1;
                    push_job.lead_action = ACT_LOW_HOLD;
                    push_job.count       = req.manual_pulses;
                end
            end
            default:
            begin
            end
        endcase

        tgt   = owpd_target(bright_next, flags_next, cfg);
        steps = owpd_steps(level_reg, tgt);

        if (apply_en && tgt != level_reg)
        begin
            if (tgt == 6'd0)
            begin
                level_next           = 6'd0;
                has_job              = 1'b1;
                push_job.lead        = 1'b1;
                push_job.lead_action = ACT_LOW_HOLD;
                push_job.count       = 6'd0;
            end
            else if (steps != 6'd0)
            begin
                level_next           = tgt;
                has_job              = 1'b1;
                push_job.lead        = 1'b0;
                push_job.lead_action = ACT_PULSE;
                push_job.count       = steps;
            end
        end

        push_job.level  = level_next;
        push_job.bright = bright_next;
    end

    assign push = accept && has_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= 6'd17;
            resumed_reg <= 1'b1;
            bright_reg  <= 8'd0;
            flags_reg   <= 3'b011;
        end
        else if (accept)
        begin
            level_reg   <= level_next;
            resumed_reg <= resumed_next;
            bright_reg  <= bright_next;
            flags_reg   <= flags_next;
        end
    end

endmodule

FILE: rtl/owpd_queue.sv
module owpd_queue
    import owpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: rtl/owpd_back.sv
module owpd_back
    import owpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  job_t        q_head,
    output logic        pop,
    owpd_res_if.source  res
);

    back_state_t state_reg;
    back_state_t state_next;
    back_state_t start_state;
    job_t        job_reg;
    logic [5:0]  left_reg;
    logic        fire;
    logic        is_last;
    logic        load;

    assign start_state = q_head.lead ? ST_LEAD : ST_PULSE;
    assign fire        = res.valid && res.ready;
    assign load        = !q_empty && ((state_reg == ST_IDLE) || (fire && is_last));
    assign pop         = load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = start_state;
                end
            end
            ST_LEAD, ST_PULSE:
            begin
                if (fire)
                begin
                    if (is_last)
                    begin
                        state_next = q_empty ? ST_IDLE : start_state;
                    end
                    else
                    begin
                        state_next = ST_PULSE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.valid               = 1'b0;
        res.action              = ACT_PULSE;
        is_last                 = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LEAD:
            begin
                res.valid  = 1'b1;
                res.action = job_reg.lead_action;
                is_last    = (job_reg.count == 6'd0);
            end
            ST_PULSE:
            begin
                res.valid  = 1'b1;
                res.action = ACT_PULSE;
                is_last    = (left_reg == 6'd1);
            end
            default:
            begin
            end
        endcase
        res.last                = is_last;
        res.level               = job_reg.level;
        res.reported_brightness = job_reg.bright;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            left_reg  <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                left_reg <= q_head.count;
            end
            else if (fire && state_reg == ST_PULSE)
            begin
                left_reg <= left_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= q_head;
        end
    end

endmodule

FILE: tb/tb_one_wire_pulse_dimming_control_top.sv
`timescale 1ns / 1ps

module tb_one_wire_pulse_dimming_control_top;
    import owpd_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 57;
    localparam int NUM_DIR         = 23;
    localparam int PREDICT         = -1;
    localparam int CHIP_STEPS      = 32;
    localparam int TOP_LEVEL       = 32;

    localparam logic [7:0] STEP_REQ [22] = '{
        8'd20,  8'd27,  8'd39,  8'd51,  8'd63,  8'd75,  8'd87,  8'd99,
        8'd111, 8'd123, 8'd135, 8'd147, 8'd159, 8'd171, 8'd183, 8'd195,
        8'd207, 8'd220, 8'd230, 8'd235, 8'd240, 8'd255
    };
    localparam logic [5:0] STEP_LVL [22] = '{
        6'd29, 6'd29, 6'd28, 6'd28, 6'd27, 6'd26, 6'd25, 6'd22,
        6'd20, 6'd18, 6'd17, 6'd16, 6'd16, 6'd14, 6'd14, 6'd12,
        6'd12, 6'd11, 6'd10, 6'd9,  6'd8,  6'd3
    };

    typedef struct packed {
        op_t        op;
        logic [7:0] brightness;
        logic       pwr;
        logic       fb;
        logic       core;
        logic [5:0] manual;
    } dim_req_t;

    typedef struct packed {
        action_t    action;
        logic       last;
        logic [5:0] level;
        logic [7:0] bright;
    } line_evt_t;

    typedef struct {
        dim_req_t   rq;
        int         exp_n;
        action_t    exp_act;
        logic [5:0] exp_level;
        logic [7:0] exp_bright;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    owpd_req_if req_ch();
    owpd_res_if res_ch();

    one_wire_pulse_dimming_control_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_evt_t pending_events [$];
    line_evt_t fresh_events [$];

    logic [5:0] lvl_now;
    logic       running;
    logic [7:0] req_bright;
    logic [2:0] req_flags;
    logic [5:0] dim_cfg;
    logic [7:0] min_cfg;

    int  errors      = 0;
    int  cycle_count = 0;
    int  sent_count  = 0;
    int  gap_odds    = 0;
    bit  quiet       = 1'b0;

    logic [7:0] ph_dim [NUM_PHASES];
    logic [7:0] ph_min [NUM_PHASES];

    dir_row_t dir_rows [NUM_DIR] = '{
        '{'{OP_UPDATE,  8'd255, 1'b1, 1'b1, 1'b0, 6'd0},  18, ACT_PULSE,    6'd3,  8'd255},
        '{'{OP_UPDATE,  8'd0,   1'b1, 1'b1, 1'b0, 6'd0},   1, ACT_LOW_HOLD, 6'd0,  8'd0},
        '{'{OP_UPDATE,  8'd1,   1'b1, 1'b1, 1'b0, 6'd0},  32, ACT_PULSE,    6'd32, 8'd1},
        '{'{OP_UPDATE,  8'd255, 1'b0, 1'b1, 1'b0, 6'd0},   1, ACT_LOW_HOLD, 6'd0,  8'd255},
        '{'{OP_UPDATE,  8'd255, 1'b1, 1'b0, 1'b0, 6'd0},   0, ACT_PULSE,    6'd0,  8'd0},
        '{'{OP_UPDATE,  8'd255, 1'b1, 1'b1, 1'b1, 6'd0},   0, ACT_PULSE,    6'd0,  8'd0},
        '{'{OP_UPDATE,  8'd20,  1'b1, 1'b1, 1'b0, 6'd0},  29, ACT_PULSE,    6'd29, 8'd20},
        '{'{OP_UPDATE,  8'd27,  1'b1, 1'b1, 1'b0, 6'd0},   0, ACT_PULSE,    6'd0,  8'd0},
        '{'{OP_UPDATE,  8'd221, 1'b1, 1'b1, 1'b0, 6'd0}, PREDICT, ACT_PULSE, 6'd0, 8'd0},
        '{'{OP_SUSPEND, 8'hAA,  1'b0, 1'b1, 1'b0, 6'h2A},  1, ACT_LOW,      6'd0,  8'd221},
        '{'{OP_SUSPEND, 8'h55,  1'b1, 1'b0, 1'b1, 6'h15},  1, ACT_LOW,      6'd0,  8'd221},
        '{'{OP_UPDATE,  8'd128, 1'b1, 1'b1, 1'b0, 6'd0},   0, ACT_PULSE,    6'd0,  8'd0},
        '{'{OP_MANUAL,  8'd0,   1'b1, 1'b1, 1'b0, 6'd32}, 33, ACT_LOW_HOLD, 6'd0,  8'd128},
        '{'{OP_MANUAL,  8'd0,   1'b1, 1'b1, 1'b0, 6'd0},   0, ACT_PULSE,    6'd0,  8'd0},
        '{'{OP_MANUAL,  8'd0,   1'b1, 1'b1, 1'b0, 6'd33},  0, ACT_PULSE,    6'd0,  8'd0},
        '{'{OP_MANUAL,  8'd0,   1'b1, 1'b1, 1'b0, 6'd63},  0, ACT_PULSE,    6'd0,  8'd0},
        '{'{OP_RESUME,  8'd0,   1'b1, 1'b1, 1'b0, 6'd0}, PREDICT, ACT_PULSE, 6'd0, 8'd0},
        '{'{OP_RESUME,  8'd0,   1'b1, 1'b1, 1'b0, 6'd0},   0, ACT_PULSE,    6'd0,  8'd0},
        '{'{OP_MANUAL,  8'd0,   1'b1, 1'b1, 1'b0, 6'd1},   2, ACT_LOW_HOLD, 6'd17, 8'd128},
        '{'{OP_UPDATE,  8'd241, 1'b1, 1'b1, 1'b0, 6'd0}, PREDICT, ACT_PULSE, 6'd0, 8'd0},
        '{'{OP_UPDATE,  8'd19,  1'b1, 1'b1, 1'b0, 6'd0}, PREDICT, ACT_PULSE, 6'd0, 8'd0},
        '{'{OP_UPDATE,  8'd0,   1'b0, 1'b0, 1'b1, 6'd0},   1, ACT_LOW_HOLD, 6'd0,  8'd0},
        '{'{OP_UPDATE,  8'd200, 1'b1, 1'b1, 1'b0, 6'd0}, PREDICT, ACT_PULSE, 6'd0, 8'd0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [5:0] target_level(input logic [7:0] b, input logic [2:0] fl);
        if (!fl[0] || !fl[1] || fl[2] || b == 8'd0)
            return 6'd0;
        if (b < min_cfg)
            return (dim_cfg > 6'(TOP_LEVEL)) ? 6'(TOP_LEVEL) : dim_cfg;
        if (b == 8'd255)
            return STEP_LVL[21];
        for (int i = 0; i < 22; i++)
            if (b <= STEP_REQ[i])
                return STEP_LVL[i];
        return 6'd0;
    endfunction

    function automatic void emit(input action_t a, input logic lst);
        line_evt_t e;
        e.action = a;
        e.last   = lst;
        e.level  = lvl_now;
        e.bright = req_bright;
        fresh_events.push_back(e);
    endfunction

    function automatic void settle_level();
        logic [5:0] tgt;
        int         n;
        tgt = target_level(req_bright, req_flags);
        if (tgt == lvl_now)
            return;
        if (tgt == 6'd0)
        begin
            lvl_now = 6'd0;
            emit(ACT_LOW_HOLD, 1'b1);
            return;
        end
        if (lvl_now <= tgt)
            n = int'(tgt) - int'(lvl_now);
        else
            n = (CHIP_STEPS - ((int'(lvl_now) - int'(tgt)) % CHIP_STEPS)) % CHIP_STEPS;
        if (n > TOP_LEVEL)
            n = TOP_LEVEL;
        if (n == 0)
            return;
        lvl_now = tgt;
        for (int k = 1; k <= n; k++)
            emit(ACT_PULSE, k == n);
    endfunction

    function automatic void predict_line_events(input dim_req_t r);
        fresh_events.delete();
        case (r.op)
            OP_UPDATE:
            begin
                req_bright = r.brightness;
                req_flags  = {r.core, r.fb, r.pwr};
                if (running)
                    settle_level();
            end
            OP_SUSPEND:
            begin
                running = 1'b0;
                lvl_now = 6'd0;
                emit(ACT_LOW, 1'b1);
            end
            OP_RESUME:
            begin
                running = 1'b1;
                settle_level();
            end
            default:
            begin
                if (r.manual >= 6'd1 && r.manual <= 6'(TOP_LEVEL))
                begin
                    emit(ACT_LOW_HOLD, 1'b0);
                    for (int k = 1; k <= int'(r.manual); k++)
                        emit(ACT_PULSE, k == int'(r.manual));
                end
            end
        endcase
    endfunction

    function automatic void commit_fresh();
        foreach (fresh_events[k])
            pending_events.push_back(fresh_events[k]);
    endfunction

    function automatic void queue_typed(input dir_row_t d);
        line_evt_t e;
        for (int k = 1; k <= d.exp_n; k++)
        begin
            e.action = (k == 1) ? d.exp_act : ACT_PULSE;
            e.last   = (k == d.exp_n);
            e.level  = d.exp_level;
            e.bright = d.exp_bright;
            pending_events.push_back(e);
        end
    endfunction

    function automatic dim_req_t random_request();
        dim_req_t r;
        int       pick;
        int       v;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            r.op = OP_UPDATE;
        else if (pick < 63)
            r.op = OP_SUSPEND;
        else if (pick < 75)
            r.op = OP_RESUME;
        else
            r.op = OP_MANUAL;
        if ($urandom_range(0, 9) < 8)
            {r.pwr, r.fb, r.core} = 3'b110;
        else
            {r.pwr, r.fb, r.core} = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 255);
            4, 5: v = int'(STEP_REQ[$urandom_range(0, 21)]) + $urandom_range(0, 2) - 1;
            6, 7: v = int'(min_cfg) + $urandom_range(0, 2) - 1;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 1;
                    2: v = 254;
                    default: v = 255;
                endcase
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        r.brightness = 8'(v);
        if ($urandom_range(0, 99) < 85)
            r.manual = 6'($urandom_range(1, 32));
        else if ($urandom_range(0, 1) == 0)
            r.manual = 6'd0;
        else
            r.manual = 6'($urandom_range(33, 63));
        return r;
    endfunction

    task automatic send_request(input dim_req_t r);
        if (sent_count % 16 == 0)
            gap_odds = $urandom_range(0, 3);
        sent_count++;
        if (!quiet && gap_odds != 0 && $urandom_range(0, 7) < gap_odds)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        @(negedge clk);
        req_ch.valid          <= 1'b1;
        req_ch.operation      <= r.op;
        req_ch.brightness     <= r.brightness;
        req_ch.power_unblank  <= r.pwr;
        req_ch.fb_unblank     <= r.fb;
        req_ch.core_suspended <= r.core;
        req_ch.manual_pulses  <= r.manual;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_line_events(r);
    endtask

    task automatic hold_for_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_DIMMING)
            dim_cfg = data[5:0];
        else
            min_cfg = data;
    endtask

    initial
    begin
        int stall_left = 0;
        int stall_odds = 0;
        int tick = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (tick % 64 == 0)
                stall_odds = $urandom_range(0, 3);
            tick++;
            if (stall_left == 0 && !quiet && stall_odds != 0
                && $urandom_range(0, 15) < stall_odds)
                stall_left = $urandom_range(1, 16);
            if (stall_left != 0 && !quiet)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        line_evt_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected result action %0d last %0d level %0d bright %0d",
                         $time, res_ch.action, res_ch.last, res_ch.level,
                         res_ch.reported_brightness);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (res_ch.action != want.action || res_ch.last != want.last
                    || res_ch.level != want.level
                    || res_ch.reported_brightness != want.bright)
                begin
                    $display("%0t: expected action %0d last %0d level %0d bright %0d, got %0d %0d %0d %0d",
                             $time, want.action, want.last, want.level, want.bright,
                             res_ch.action, res_ch.last, res_ch.level,
                             res_ch.reported_brightness);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("one_wire_pulse_dimming_control_top test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_IDX_DIMMING;
        cfg_data              = 8'd0;
        req_ch.valid          = 1'b0;
        req_ch.operation      = OP_UPDATE;
        req_ch.brightness     = 8'd0;
        req_ch.power_unblank  = 1'b0;
        req_ch.fb_unblank     = 1'b0;
        req_ch.core_suspended = 1'b0;
        req_ch.manual_pulses  = 6'd0;

        lvl_now    = 6'd17;
        running    = 1'b1;
        req_bright = 8'd0;
        req_flags  = 3'b011;
        dim_cfg    = 6'd32;
        min_cfg    = 8'd20;

        ph_dim = '{8'd5, 8'hC0, 8'hFF, 8'd1, 8'd32, 8'hC7, 8'd0};
        ph_min = '{8'd20, 8'd100, 8'd255, 8'd1, 8'd128, 8'd0, 8'd0};
        ph_min[5] = 8'($urandom_range(1, 255));
        ph_dim[6] = 8'($urandom_range(1, 32));
        ph_min[6] = 8'($urandom_range(1, 255));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].rq);
            if (dir_rows[i].exp_n == PREDICT)
                commit_fresh();
            else
                queue_typed(dir_rows[i]);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            hold_for_idle();
            write_cfg(CFG_IDX_DIMMING, ph_dim[p]);
            write_cfg(CFG_IDX_MIN, ph_min[p]);
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            repeat (ITEMS_PER_PHASE)
            begin
                if (!quiet && $urandom_range(0, 49) == 0)
                    hold_for_idle();
                send_request(random_request());
                commit_fresh();
            end
        end

        hold_for_idle();
        if (errors == 0)
            $display("one_wire_pulse_dimming_control_top test passed");
        else
            $display("one_wire_pulse_dimming_control_top test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/owpd_pkg.sv
rtl/owpd_if.sv
rtl/owpd_front.sv
rtl/owpd_queue.sv
rtl/owpd_back.sv
rtl/one_wire_pulse_dimming_control_top.sv
tb/tb_one_wire_pulse_dimming_control_top.sv
